// ===== design/tsps_pkg.sv =====
// Shared constants and types for the time-slot page select block.
package tsps_pkg;

	// Field widths.
	localparam int TIME_W    = 32;
	localparam int DVD_W     = TIME_W - 1;
	localparam int DVD_CNT_W = $clog2(DVD_W);
	localparam int DUR_W     = 16;
	localparam int PAGE_W    = 3;
	localparam int CFG_IDX_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION_0 = 3'd1;

	// Reset values of the configuration registers.
	localparam logic [PAGE_W-1:0] PAGE_COUNT_RST = 3'd1;
	localparam logic [DUR_W-1:0]  DURATION_0_RST = 16'd900;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_SCAN,
		ST_WAIT
	} state_t;

endpackage

// ===== design/time_slot_page_select.sv =====
// Top level of the time-slot page select block.
//
// Given elapsed seconds, reports which page of a cyclic rotation is on display.
// An item with fewer than two active pages finishes in the cycle it is taken.
// Otherwise the sequencer adds the active durations one page per cycle, reduces
// the clamped time modulo that total in a bit-serial unit, then scans the pages
// one per cycle until one matches. The result is loaded into the output register,
// or parks until that register drains. Items are taken one at a time: a new item
// is taken only once the sequencer is back in idle, and a finished result sits in
// the output register while the next item is taken.
// Configuration is written through wr_en, wr_index and wr_data while idle; this
// binds the user, as the block itself does not enforce it.
module time_slot_page_select #(
	parameter int PAGE_SLOTS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tsps_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tsps_pkg::DUR_W-1:0]    wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [tsps_pkg::TIME_W-1:0] elapsed_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tsps_pkg::PAGE_W-1:0]   page_index
);
	import tsps_pkg::*;

	localparam int TOT_W = DUR_W + $clog2(PAGE_SLOTS);
	localparam logic [PAGE_W-1:0] SLOTS_C = PAGE_W'(PAGE_SLOTS);

	// Configuration registers.
	logic [PAGE_W-1:0] page_count_q;
	logic [DUR_W-1:0]  dur_q [PAGE_SLOTS];

	// Sequencer and datapath.
	state_t            state_q;
	state_t            state_d;
	logic [DVD_W-1:0]  time_q;
	logic [PAGE_W-1:0] cnt_q;
	logic [TOT_W-1:0]  acc_q;
	logic [PAGE_W-1:0] res_q;
	logic              out_valid_q;
	logic [PAGE_W-1:0] page_q;

	logic [PAGE_W-1:0] eff_cnt;
	logic [PAGE_W-1:0] eff_last;
	logic [DUR_W-1:0]  dur_sel;
	logic [TOT_W-1:0]  sum_next;
	logic              out_free;
	logic              ld_start;
	logic              step;
	logic              scan_init;
	logic              div_start;
	logic              fin;
	logic [PAGE_W-1:0] fin_val;
	logic              out_load;
	logic [PAGE_W-1:0] out_data;
	logic              mod_done;
	logic [TOT_W-1:0]  mod_rem;

	// Configuration writes; indexes beyond the implemented slots are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PAGE_COUNT_RST;
			for (int j = 0; j < PAGE_SLOTS; j++) begin
				dur_q[j] <= (j == 0) ? DURATION_0_RST : '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_PAGE_COUNT) begin
				page_count_q <= wr_data[PAGE_W-1:0];
			end
			for (int j = 0; j < PAGE_SLOTS; j++) begin
				if (wr_index == REG_DURATION_0 + CFG_IDX_W'(j)) begin
					dur_q[j] <= wr_data;
				end
			end
		end
	end

	// Active page count saturates at the number of slots.
	always_comb begin
		eff_cnt  = (page_count_q > SLOTS_C) ? SLOTS_C : page_count_q;
		eff_last = eff_cnt - 1'b1;
	end

	// Duration of the page under the counter, and the running sum through it.
	always_comb begin
		dur_sel = '0;
		for (int j = 0; j < PAGE_SLOTS; j++) begin
			if (cnt_q == PAGE_W'(j)) begin
				dur_sel = dur_q[j];
			end
		end
		sum_next = acc_q + TOT_W'(dur_sel);
	end

	// Bit-serial modulo of the clamped time by the total duration.
	tsps_serial_mod #(
		.DIV_W(TOT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (time_q),
		.divisor  (sum_next),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d   = state_q;
		ld_start  = 1'b0;
		step      = 1'b0;
		scan_init = 1'b0;
		div_start = 1'b0;
		fin       = 1'b0;
		fin_val   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (eff_cnt <= PAGE_W'(1)) begin
						fin = 1'b1;
					end else begin
						ld_start = 1'b1;
						state_d  = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				if (cnt_q == eff_last) begin
					if (sum_next == '0) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end else begin
					step = 1'b1;
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					scan_init = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((mod_rem < sum_next) || (cnt_q == eff_last)) begin
					fin     = 1'b1;
					fin_val = cnt_q;
					state_d = ST_IDLE;
				end else begin
					step = 1'b1;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// A result that finds the output register full parks until it drains.
		if (fin && !out_free) begin
			state_d = ST_WAIT;
		end
		out_load = (fin || (state_q == ST_WAIT)) && out_free;
		out_data = (state_q == ST_WAIT) ? res_q : fin_val;
	end

	// Working registers: clamped time, page counter, running sum, parked result and output page.
	always_ff @(posedge clk) begin
		if (ld_start) begin
			time_q <= elapsed_time[TIME_W-1] ? '0 : elapsed_time[DVD_W-1:0];
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (scan_init) begin
			cnt_q <= '0;
			acc_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
			acc_q <= sum_next;
		end
		if (fin && !out_free) begin
			res_q <= fin_val;
		end
		if (out_load) begin
			page_q <= out_data;
		end
	end

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign page_index = page_q;

`ifndef SYNTHESIS
	// The modulo unit only reports completion while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_DIV))
		else $error("modulo done outside the divide phase");

	// The page scan never runs past the last active page.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q < eff_cnt))
		else $error("page scan beyond the active pages");

	// A delivered page index always names an implemented slot.
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (page_index < SLOTS_C))
		else $error("page index out of range");
`endif

endmodule

// ===== design/tsps_serial_mod.sv =====
// Bit-serial restoring modulo unit: one dividend bit per cycle.
module tsps_serial_mod #(
	parameter int DIV_W = 19
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tsps_pkg::DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [DIV_W-1:0]          remainder
);
	import tsps_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DVD_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     div_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 fits;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		diff    = shifted - {1'b0, div_q};
		fits    = (shifted >= {1'b0, div_q});
	end

	// Control: busy while the dividend bits are shifted in, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: dividend shifts out MSB first while the partial remainder builds up.
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= DVD_CNT_W'(DVD_W - 1);
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== tb/page_select_checker.sv =====
// Checker that predicts and compares every page index the block returns.
`timescale 1ns / 100ps

module page_select_checker #(
	parameter int PAGE_SLOTS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [tsps_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [tsps_pkg::DUR_W-1:0]         wr_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [tsps_pkg::TIME_W-1:0] elapsed_time,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [tsps_pkg::PAGE_W-1:0]        page_index,
	output int                                 fail_count,
	output int                                 pending
);
	import tsps_pkg::*;

	localparam int DURATION_REGS = 6;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		logic [PAGE_W-1:0] page;
	} page_query_t;

	page_query_t       expected_pages [$];
	page_query_t       oldest;
	page_query_t       fresh;
	logic [PAGE_W-1:0] active_pages;
	logic [DUR_W-1:0]  hold_time [DURATION_REGS];
	int                bad_beats;

	// Page on display at the given time under the current schedule.
	function automatic logic [PAGE_W-1:0] page_at(input logic [TIME_W-1:0] raw);
		int                n;
		int                i;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] pos;
		logic [TIME_W-1:0] acc;
		logic [PAGE_W-1:0] page;
		bit                found;
		n = (active_pages > PAGE_SLOTS) ? PAGE_SLOTS : active_pages;
		if (n > DURATION_REGS) n = DURATION_REGS;
		if (n <= 1) return '0;
		// A negative time shows the start of the rotation.
		t = raw[TIME_W-1] ? '0 : raw;
		total = '0;
		for (i = 0; i < n; i++) total += hold_time[i];
		if (total == 0) return '0;
		pos = t % total;
		acc = '0;
		page = PAGE_W'(n - 1);
		found = 1'b0;
		for (i = 0; i < n; i++) begin
			acc += hold_time[i];
			if (!found && pos < acc) begin
				page = PAGE_W'(i);
				found = 1'b1;
			end
		end
		return page;
	endfunction

	// Shadow the schedule, queue a prediction per query beat, check each result beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_pages.delete();
			active_pages = PAGE_COUNT_RST;
			foreach (hold_time[j]) hold_time[j] = '0;
			hold_time[0] = DURATION_0_RST;
			bad_beats = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// Each result beat answers the oldest query still open.
			if (out_valid && !out_stall) begin
				if (expected_pages.size() == 0) begin
					if (bad_beats < REPORT_LIMIT)
						$display("unexpected result beat: page %0d", page_index);
					bad_beats++;
				end else begin
					oldest = expected_pages.pop_front();
					if (page_index !== oldest.page) begin
						if (bad_beats < REPORT_LIMIT)
							$display("page mismatch at elapsed %0d: expected %0d, got %0d",
								$signed(oldest.elapsed), oldest.page, page_index);
						bad_beats++;
					end
				end
			end

			// Predict the page for every query beat taken.
			if (in_valid && !in_stall) begin
				fresh.elapsed = elapsed_time;
				fresh.page = page_at(elapsed_time);
				expected_pages.push_back(fresh);
			end

			// Follow register writes; indexes past the duration registers are ignored.
			if (wr_en) begin
				if (wr_index == REG_PAGE_COUNT) begin
					active_pages = wr_data[PAGE_W-1:0];
				end else if (wr_index >= REG_DURATION_0 &&
					wr_index < REG_DURATION_0 + DURATION_REGS) begin
					hold_time[wr_index - REG_DURATION_0] = wr_data;
				end
			end

			pending <= expected_pages.size();
			fail_count <= bad_beats;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Clock, reset, stimulus and verdict for the time-slot page select testbench.
`timescale 1ns / 100ps

module tb_top;
	import tsps_pkg::*;

	localparam int PAGE_SLOTS    = 6;
	localparam int DURATION_REGS = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 84;

	localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      wr_en;
	logic [CFG_IDX_W-1:0]      wr_index;
	logic [DUR_W-1:0]          wr_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [TIME_W-1:0]  elapsed_time;
	logic                      out_valid;
	logic                      out_stall;
	logic [PAGE_W-1:0]         page_index;

	int                        idle_pct = 0;
	int                        stall_pct = 0;
	bit                        hold_req = 1'b0;
	int                        fail_count;
	int                        pending;
	int                        queries_sent = 0;
	int                        settings_used = 1;
	logic [PAGE_W-1:0]         sched_count;
	logic [DUR_W-1:0]          sched_dur [DURATION_REGS];

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	time_slot_page_select #(
		.PAGE_SLOTS(PAGE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.elapsed_time(elapsed_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_index(page_index)
	);

	page_select_checker #(
		.PAGE_SLOTS(PAGE_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.elapsed_time(elapsed_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_index(page_index),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int k;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: end the run when no beat moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("no beat moved for %0d cycles", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic set_flow(input flow_t flow);
		case (flow)
			FLOW_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			FLOW_SENDER_GAPS: begin
				idle_pct = 58;
				stall_pct = 0;
			end
			FLOW_RECEIVER_STALLS: begin
				idle_pct = 0;
				stall_pct = 58;
			end
			default: begin
				idle_pct = 23;
				stall_pct = 23;
			end
		endcase
	endtask

	// Offer one query beat after a random gap and hold it until taken.
	task automatic send_query(input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_time <= t;
		do @(posedge clk); while (in_stall);
		queries_sent++;
	endtask

	// Stop offering and wait until every open query has been answered.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the whole schedule, sometimes followed by a write to the unmapped index.
	task automatic apply_schedule();
		int          i;
		logic [12:0] junk;
		junk = 13'($urandom);
		wr_en <= 1'b1;
		wr_index <= REG_PAGE_COUNT;
		wr_data <= {junk, sched_count};
		@(posedge clk);
		for (i = 0; i < DURATION_REGS; i++) begin
			wr_index <= CFG_IDX_W'(REG_DURATION_0 + i);
			wr_data <= sched_dur[i];
			@(posedge clk);
		end
		if ($urandom_range(1) == 1) begin
			wr_index <= UNMAPPED_REG;
			wr_data <= DUR_W'($urandom);
			@(posedge clk);
		end
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// Mostly multi-page rotations, with saturated, trivial and zero-length pages mixed in.
	task automatic random_schedule();
		int i;
		int r;
		r = $urandom_range(99);
		if (r < 70) sched_count = PAGE_W'($urandom_range(6, 2));
		else if (r < 80) sched_count = 3'd7;
		else sched_count = PAGE_W'($urandom_range(1, 0));
		for (i = 0; i < DURATION_REGS; i++) begin
			r = $urandom_range(99);
			if (r < 15) sched_dur[i] = '0;
			else if (r < 27) sched_dur[i] = '1;
			else if (r < 70) sched_dur[i] = DUR_W'($urandom_range(30, 1));
			else sched_dur[i] = DUR_W'($urandom);
		end
	endtask

	// Times spread over the rotation, on page boundaries, at the extremes, or anywhere.
	function automatic logic [TIME_W-1:0] pick_time();
		int          n;
		int          j;
		int          r;
		int          pick;
		logic [31:0] span;
		logic [31:0] boundary;
		n = (sched_count > PAGE_SLOTS) ? PAGE_SLOTS : sched_count;
		span = '0;
		for (j = 0; j < n; j++) span += sched_dur[j];
		r = $urandom_range(99);
		if (span == 0 || r < 25) return $urandom;
		if (r < 35) begin
			case ($urandom_range(4))
				0: return 32'h0000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0000;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		if (r < 45) return $urandom & 32'h7FFF_FFFF;
		if (r < 70) begin
			pick = $urandom_range(n - 1, 0);
			boundary = '0;
			for (j = 0; j <= pick; j++) boundary += sched_dur[j];
			return $urandom_range(5000) * span + boundary - $urandom_range(1);
		end
		return $urandom_range(3 * span);
	endfunction

	initial begin : stimulus
		int p;
		int k;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		elapsed_time = '0;
		sched_count = PAGE_COUNT_RST;
		sched_dur = '{DURATION_0_RST, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset schedule has one page, so page 0 always shows.
		set_flow(FLOW_FREE);
		send_query(32'h0000_0000);
		send_query(32'h7FFF_FFFF);
		send_query(32'h8000_0000);
		wait_results();

		// Three pages: both sides of every boundary, the wrap, and a negative time.
		sched_count = 3'd3;
		sched_dur = '{16'd10, 16'd20, 16'd30, 16'd7, 16'd7, 16'd7};
		apply_schedule();
		send_query(32'd0);
		send_query(32'd9);
		send_query(32'd10);
		send_query(32'd29);
		send_query(32'd30);
		send_query(32'd59);
		send_query(32'd60);
		send_query(32'hFFFF_FFFB);
		wait_results();

		// Page count of seven saturates to six slots of the longest duration.
		set_flow(FLOW_BOTH);
		sched_count = 3'd7;
		sched_dur = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		apply_schedule();
		send_query(32'd0);
		send_query(32'd65534);
		send_query(32'd65535);
		send_query(32'd393209);
		send_query(32'd393210);
		wait_results();

		// Active durations sum to zero; only inactive slots are nonzero.
		sched_count = 3'd4;
		sched_dur = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 16'd500};
		apply_schedule();
		send_query(32'd123);
		send_query(32'hFFFF_FFFF);
		wait_results();

		// No active pages at all.
		sched_count = 3'd0;
		sched_dur = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5};
		apply_schedule();
		send_query(32'd77);
		wait_results();

		// Zero-length pages are skipped over.
		set_flow(FLOW_FREE);
		sched_count = 3'd5;
		sched_dur = '{16'd0, 16'd7, 16'd0, 16'd0, 16'd3, 16'd9};
		apply_schedule();
		send_query(32'd0);
		send_query(32'd6);
		send_query(32'd7);
		send_query(32'd9);
		send_query(32'd10);
		wait_results();

		// Random schedules, cycling through the four traffic patterns.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			random_schedule();
			apply_schedule();
			set_flow(flow_t'(p % 4));
			// Back up the block behind a long output hold-off.
			if (p == 4) hold_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2 && (p == 2 || $urandom_range(2) == 0))
					wait_results();
				send_query(pick_time());
			end
			wait_results();
		end

		$display("Checked %0d page queries over %0d schedule settings.",
			queries_sent, settings_used);
		$display("Traffic mixed free flow, sender gaps, receiver stalls and a %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
